@@ hdl/csp_pkg.sv @@
`default_nettype none

package csp_pkg;

  localparam int COORD_BITS = 20;
  localparam int SUM_W      = COORD_BITS + 1;
  localparam int PAIR_W     = 2 * SUM_W;
  localparam int VEC_W      = 3 * COORD_BITS;
  localparam int CSP_W      = 46;
  localparam int CFG_W      = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd12;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] delta_x;
    logic signed [COORD_BITS-1:0] delta_y;
    logic signed [COORD_BITS-1:0] delta_z;
    logic                         last_neighbour;
  } in_word_t;

  typedef struct packed {
    logic [CSP_W-1:0] csp_value;
    logic             too_few;
    logic             too_many;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic sum_step;
    logic out_load;
  } csp_cmd_t;

  typedef struct packed {
    logic store_ok;
    logic last_item;
    logic pipe_busy;
    logic out_busy;
  } csp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAIR,
    ST_DRAIN,
    ST_SUM
  } csp_state_e;

endpackage

`default_nettype wire

@@ hdl/csp_ctrl.sv @@
`default_nettype none

module csp_ctrl import csp_pkg::*; #(
  parameter int CNT_W  = 6,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire csp_status_t       status_i,
  input  wire logic [CNT_W-1:0]  vec_count_i,
  input  wire logic [CNT_W-1:0]  k_half_i,
  output csp_cmd_t               cmd_o,
  output logic [ADDR_W-1:0]      rd_addr_o
);

  csp_state_e        state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] npair_q, npair_d;
  logic [ADDR_W:0]   idx_inc;
  logic              pair_done;
  logic              sum_done;
  logic              count_nz;

  assign idx_inc   = {1'b0, idx_q} + (ADDR_W+1)'(1);
  assign pair_done = idx_inc == {1'b0, npair_q};
  assign sum_done  = idx_inc == (ADDR_W+1)'(k_half_i);
  assign count_nz  = vec_count_i != '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (status_i.store_ok && count_nz) ? ST_PAIR : ST_DRAIN;
        end
      end
      ST_PAIR: begin
        if (pair_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = status_i.last_item ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (sum_done && !status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    npair_d = npair_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        // pairs to form = vectors already stored before this one
        if (in_valid_i) npair_d = vec_count_i[ADDR_W-1:0];
      end
      ST_PAIR:  idx_d = pair_done ? '0 : idx_inc[ADDR_W-1:0];
      ST_DRAIN: idx_d = '0;
      ST_SUM: begin
        if (!sum_done) idx_d = idx_inc[ADDR_W-1:0];
      end
      default: idx_d = '0;
    endcase
  end

  always_comb begin
    in_stall_o     = state_q != ST_IDLE;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue    = state_q == ST_PAIR;
    // hold the final step while the output register still has an untaken word
    cmd_o.sum_step = (state_q == ST_SUM) && !(sum_done && status_i.out_busy);
    cmd_o.out_load = (state_q == ST_SUM) && sum_done && !status_i.out_busy;
    rd_addr_o      = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      npair_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      npair_q <= npair_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/csp_datapath.sv @@
`default_nettype none

module csp_datapath import csp_pkg::*; #(
  parameter int MAX_NEIGHBOURS = 32,
  parameter int CNT_W          = 6,
  parameter int ADDR_W         = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire in_word_t          in_word_i,
  input  wire csp_cmd_t          cmd_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  input  wire logic              out_stall_i,
  output csp_status_t            status_o,
  output logic [CNT_W-1:0]       vec_count_o,
  output logic [CNT_W-1:0]       k_half_o,
  output logic                   out_valid_o,
  output out_word_t              out_word_o
);

  localparam int PAIR_DEPTH = MAX_NEIGHBOURS / 2;
  localparam int K_TOP      = (MAX_NEIGHBOURS / 2) * 2;
  localparam int KW         = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]  cfg_q;
  logic [KW-1:0]     k_raw, k_clamp;
  logic [CNT_W-1:0]  k_eff;
  logic [CNT_W-1:0]  count_q;
  logic              overflow_q;
  logic              last_q;
  logic              store_ok;

  logic signed [COORD_BITS-1:0] vx_q, vy_q, vz_q;
  logic [VEC_W-1:0]  mem [MAX_NEIGHBOURS];
  logic [VEC_W-1:0]  rd_q;
  logic signed [COORD_BITS-1:0] rx, ry, rz;

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic signed [SUM_W-1:0]  sx_q, sy_q, sz_q;
  logic signed [PAIR_W-1:0] mx, my, mz;
  logic [PAIR_W-1:0]        qx_q, qy_q, qz_q;
  logic [PAIR_W-1:0]        pair_q;

  logic [PAIR_W-1:0] pairs_q [PAIR_DEPTH];
  logic [PAIR_DEPTH-1:0] gt;

  logic [CSP_W-1:0]  acc_q, acc_d;
  logic [CSP_W:0]    sum_ext;
  logic              out_valid_q;
  out_word_t         out_q;

  // neighbour count: drop the odd bit, clamp to 2 .. store size rounded down to even
  always_comb begin
    k_raw = KW'({cfg_q[CFG_W-1:1], 1'b0});
    if (k_raw < KW'(2)) k_clamp = KW'(2);
    else if (k_raw > KW'(K_TOP)) k_clamp = KW'(K_TOP);
    else k_clamp = k_raw;
    k_eff = k_clamp[CNT_W-1:0];
  end

  assign store_ok    = count_q < k_eff;
  assign vec_count_o = count_q;
  assign k_half_o    = k_eff >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // per-particle bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
      last_q     <= 1'b0;
    end else if (cmd_i.out_load) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (cmd_i.accept) begin
      last_q <= in_word_i.last_neighbour;
      if (store_ok) count_q <= count_q + CNT_W'(1);
      else overflow_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      vx_q <= in_word_i.delta_x;
      vy_q <= in_word_i.delta_y;
      vz_q <= in_word_i.delta_z;
    end
  end

  // vector store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store_ok) begin
      mem[count_q[ADDR_W-1:0]] <= {in_word_i.delta_x, in_word_i.delta_y, in_word_i.delta_z};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) rd_q <= mem[rd_addr_i];
  end

  assign rx = rd_q[VEC_W-1 -: COORD_BITS];
  assign ry = rd_q[2*COORD_BITS-1 -: COORD_BITS];
  assign rz = rd_q[COORD_BITS-1:0];

  // pair pipeline: read, component sums, squares, total, insert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign mx = sx_q * sx_q;
  assign my = sy_q * sy_q;
  assign mz = sz_q * sz_q;

  always_ff @(posedge clk_i) begin
    sx_q   <= SUM_W'(vx_q) + SUM_W'(rx);
    sy_q   <= SUM_W'(vy_q) + SUM_W'(ry);
    sz_q   <= SUM_W'(vz_q) + SUM_W'(rz);
    qx_q   <= $unsigned(mx);
    qy_q   <= $unsigned(my);
    qz_q   <= $unsigned(mz);
    pair_q <= qx_q + qy_q + qz_q;
  end

  // sorted list of smallest pair values, ascending
  always_comb begin
    for (int j = 0; j < PAIR_DEPTH; j++) gt[j] = pairs_q[j] > pair_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < PAIR_DEPTH; j++) pairs_q[j] <= '1;
    end else if (cmd_i.out_load) begin
      for (int j = 0; j < PAIR_DEPTH; j++) pairs_q[j] <= '1;
    end else if (cmd_i.sum_step) begin
      // pop the head into the accumulator
      for (int j = 0; j < PAIR_DEPTH - 1; j++) pairs_q[j] <= pairs_q[j+1];
      pairs_q[PAIR_DEPTH-1] <= '1;
    end else if (v4_q) begin
      for (int j = 0; j < PAIR_DEPTH; j++) begin
        if (gt[j]) begin
          if (j == 0) pairs_q[j] <= pair_q;
          else if (!gt[j-1]) pairs_q[j] <= pair_q;
          else pairs_q[j] <= pairs_q[j-1];
        end
      end
    end
  end

  // saturating accumulate
  assign sum_ext = {1'b0, acc_q} + (CSP_W+1)'(pairs_q[0]);
  assign acc_d   = sum_ext[CSP_W] ? '1 : sum_ext[CSP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.out_load) begin
      acc_q <= '0;
    end else if (cmd_i.sum_step) begin
      acc_q <= acc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.csp_value <= store_ok ? '0 : acc_d;
      out_q.too_few   <= store_ok;
      out_q.too_many  <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    status_o.store_ok  = store_ok;
    status_o.last_item = last_q;
    status_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
    status_o.out_busy  = out_valid_q & out_stall_i;
  end

endmodule

`default_nettype wire

@@ hdl/centrosymmetry_parameter_top.sv @@
// centrosymmetry parameter of one particle from its neighbour vectors.
// input channel (in_valid_i / in_stall_o, in_word_i): one neighbour vector
// per word, signed x, y, z and a last flag; words of one particle in order.
// output channel (out_valid_o / out_stall_i, out_word_o): one word per
// particle, after the word marked last: csp value, too_few, too_many.
// config channel (cfg_valid_i / cfg_ready_o): neighbour count K, always ready.
// a vector arriving with c vectors already stored is paired with each of them:
// one pair sum per cycle is read from the vector store, then a 4-stage
// sum / square / add / sorted-insert pipeline drains.
// after the last vector the K/2 smallest pair values are popped and summed.
// a word is taken only while in_stall_o is low (block idle).
// a finished result sits in the output register; the next particle may run
// meanwhile and only stalls at its own final sum step while the receiver
// still stalls the previous word.
// reset clears counts, flags and the pair list and sets K to 12; the vector
// store needs no clearing since only written entries are read.
`default_nettype none

module centrosymmetry_parameter_top import csp_pkg::*; #(
  parameter int MAX_NEIGHBOURS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_word_t         in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_word_t             out_word_o
);

  localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int ADDR_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

  csp_cmd_t          cmd;
  csp_status_t       status;
  logic [CNT_W-1:0]  vec_count;
  logic [CNT_W-1:0]  k_half;
  logic [ADDR_W-1:0] rd_addr;

  assign cfg_ready_o = 1'b1;

  csp_ctrl #(
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .vec_count_i (vec_count),
    .k_half_i    (k_half),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  csp_datapath #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .CNT_W          (CNT_W),
    .ADDR_W         (ADDR_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .vec_count_o (vec_count),
    .k_half_o    (k_half),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // result never formed with pairs still in flight
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !status.pipe_busy)
    else $error("result loaded with pair pipeline busy");

  // a waiting word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten");

  // new vector only taken once the previous one is fully paired
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !status.pipe_busy)
    else $error("vector accepted while pairs pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_count <= CNT_W'(MAX_NEIGHBOURS))
    else $error("vector count beyond store size");

endmodule

`default_nettype wire
